### rtl/core/ssdt_pkg.sv
// Shared widths, state codes and controller/datapath interface types for the dedup table.
package ssdt_pkg;

  localparam int MAC_W = 48;
  localparam int SEQ_W = 8;

  typedef struct packed {
    logic [MAC_W-1:0] mac;
    logic [SEQ_W-1:0] seq;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE    = 3'b001,
    ST_SEARCH  = 3'b010,
    ST_DELIVER = 3'b100
  } state_t;

  typedef struct packed {
    logic accept;
    logic search;
    logic upd_wr;
    logic ins_wr;
    logic res_ld;
    logic res_val;
    logic out_ld;
  } cmd_t;

  typedef struct packed {
    logic trivial;
    logic hit;
    logic hit_seq_eq;
    logic miss_done;
    logic out_free;
  } sts_t;

endpackage

### rtl/core/ssdt_ctrl.sv
// Controller state machine sequencing accept, table search, entry update or insert and result delivery.
module ssdt_ctrl
  import ssdt_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        priority if (sts.trivial) begin
          cmd.res_ld  = 1'b1;
          cmd.res_val = 1'b0;
          state_nxt   = ST_DELIVER;
        end else if (sts.hit) begin
          cmd.res_ld  = 1'b1;
          cmd.res_val = sts.hit_seq_eq;
          cmd.upd_wr  = !sts.hit_seq_eq;
          state_nxt   = ST_DELIVER;
        end else if (sts.miss_done) begin
          cmd.res_ld  = 1'b1;
          cmd.res_val = 1'b0;
          cmd.ins_wr  = 1'b1;
          state_nxt   = ST_DELIVER;
        end else begin
          cmd.search = 1'b1;
        end
      end
      ST_DELIVER: begin
        if (sts.out_free) begin
          cmd.out_ld = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### rtl/core/ssdt_datapath.sv
// Datapath: sender table memory, ring pointers, serial search pipeline and output register.
module ssdt_datapath
  import ssdt_pkg::*;
#(
  parameter int MAX_SENDERS = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [MAC_W-1:0] in_sender_mac,
  input  logic             in_sender_present,
  input  logic [SEQ_W-1:0] in_seq_id,
  input  logic             out_stall,
  output logic             out_valid,
  output logic             out_is_duplicate,
  input  cmd_t             cmd,
  output sts_t             sts
);

  localparam int SLOT_W = (MAX_SENDERS > 1) ? $clog2(MAX_SENDERS) : 1;
  localparam int CNT_W  = $clog2(MAX_SENDERS + 1);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(MAX_SENDERS - 1);
  localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(MAX_SENDERS);
  localparam logic [CNT_W:0]    DEPTH_EXT = (CNT_W + 1)'(MAX_SENDERS);

  entry_t entry_mem_r [MAX_SENDERS];
  entry_t rd_data_r;

  logic [MAC_W-1:0]  mac_r;
  logic              present_r;
  logic [SEQ_W-1:0]  seq_r;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [SLOT_W-1:0] oldest_r, oldest_nxt;
  logic [SLOT_W-1:0] rd_slot_r, rd_slot_nxt;
  logic [SLOT_W-1:0] hit_slot_r, hit_slot_nxt;
  logic [CNT_W-1:0]  iss_cnt_r, iss_cnt_nxt;
  logic [CNT_W-1:0]  cmp_cnt_r, cmp_cnt_nxt;
  logic              rd_vld_r, rd_vld_nxt;
  logic              res_r, res_nxt;
  logic              out_vld_r, out_vld_nxt;
  logic              out_dup_r, out_dup_nxt;

  logic              rd_en;
  logic              full;
  logic [CNT_W:0]    ins_sum;
  logic [SLOT_W-1:0] ins_slot;
  logic              wr_en;
  logic [SLOT_W-1:0] wr_slot;

  assign full    = (count_r == FULL_CNT);
  assign ins_sum = (CNT_W + 1)'(oldest_r) + (CNT_W + 1)'(count_r);
  assign ins_slot = (ins_sum >= DEPTH_EXT) ? SLOT_W'(ins_sum - DEPTH_EXT) : SLOT_W'(ins_sum);
  assign rd_en   = cmd.search && (iss_cnt_r < count_r);
  assign wr_en   = cmd.upd_wr || cmd.ins_wr;
  assign wr_slot = cmd.upd_wr ? hit_slot_r : (full ? oldest_r : ins_slot);

  assign sts.trivial    = (seq_r == '0) || !present_r;
  assign sts.hit        = rd_vld_r && (rd_data_r.mac == mac_r);
  assign sts.hit_seq_eq = (rd_data_r.seq == seq_r);
  assign sts.miss_done  = !rd_vld_r && (cmp_cnt_r == count_r);
  assign sts.out_free   = !out_vld_r || !out_stall;

  assign out_valid        = out_vld_r;
  assign out_is_duplicate = out_dup_r;

  always_comb begin
    count_nxt    = count_r;
    oldest_nxt   = oldest_r;
    rd_slot_nxt  = rd_slot_r;
    hit_slot_nxt = hit_slot_r;
    iss_cnt_nxt  = iss_cnt_r;
    cmp_cnt_nxt  = cmp_cnt_r;
    rd_vld_nxt   = 1'b0;
    res_nxt      = res_r;
    out_vld_nxt  = out_vld_r;
    out_dup_nxt  = out_dup_r;

    if (cmd.accept) begin
      rd_slot_nxt = oldest_r;
      iss_cnt_nxt = '0;
      cmp_cnt_nxt = '0;
    end

    if (rd_en) begin
      rd_vld_nxt   = 1'b1;
      hit_slot_nxt = rd_slot_r;
      rd_slot_nxt  = (rd_slot_r == LAST_SLOT) ? '0 : rd_slot_r + SLOT_W'(1);
      iss_cnt_nxt  = iss_cnt_r + CNT_W'(1);
    end

    if (cmd.search && rd_vld_r) begin
      cmp_cnt_nxt = cmp_cnt_r + CNT_W'(1);
    end

    if (cmd.ins_wr) begin
      if (full) begin
        oldest_nxt = (oldest_r == LAST_SLOT) ? '0 : oldest_r + SLOT_W'(1);
      end else begin
        count_nxt = count_r + CNT_W'(1);
      end
    end

    if (cmd.res_ld) begin
      res_nxt = cmd.res_val;
    end

    if (cmd.out_ld) begin
      out_vld_nxt = 1'b1;
      out_dup_nxt = res_r;
    end else if (out_vld_r && !out_stall) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      oldest_r  <= '0;
      rd_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      count_r   <= count_nxt;
      oldest_r  <= oldest_nxt;
      rd_vld_r  <= rd_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_slot_r  <= rd_slot_nxt;
    hit_slot_r <= hit_slot_nxt;
    iss_cnt_r  <= iss_cnt_nxt;
    cmp_cnt_r  <= cmp_cnt_nxt;
    res_r      <= res_nxt;
    out_dup_r  <= out_dup_nxt;
    if (cmd.accept) begin
      mac_r     <= in_sender_mac;
      present_r <= in_sender_present;
      seq_r     <= in_seq_id;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= entry_mem_r[rd_slot_r];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry_mem_r[wr_slot] <= '{mac: mac_r, seq: seq_r};
    end
  end

endmodule

### rtl/core/sender_sequence_dedup_table_core.sv
// Top level of the per-sender sequence id duplicate filter.
//
//   channel  direction  handshake            payload
//   in       input      in_valid/in_stall    in_sender_mac, in_sender_present, in_seq_id
//   out      output     out_valid/out_stall  out_is_duplicate
//
// A miss searches all count stored senders (up to MAX_SENDERS); the serial search through the table
// memory's single read port reads one entry per cycle. A hit ends the search at its position,
// and an absent sender or zero id skips the search. Input stalls until the output register loads
// and accepts again in the cycle after. Reset clears state, count, ring pointer and the read and
// output valid flags, not the table contents.
// A stalled result holds in the output register; the next transaction waits behind it.
module sender_sequence_dedup_table_core
  import ssdt_pkg::*;
#(
  parameter int MAX_SENDERS = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [MAC_W-1:0] in_sender_mac,
  input  logic             in_sender_present,
  input  logic [SEQ_W-1:0] in_seq_id,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             out_is_duplicate
);

  cmd_t cmd;
  sts_t sts;

  ssdt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  ssdt_datapath #(
    .MAX_SENDERS (MAX_SENDERS)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_sender_mac     (in_sender_mac),
    .in_sender_present (in_sender_present),
    .in_seq_id         (in_seq_id),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_is_duplicate  (out_is_duplicate),
    .cmd               (cmd),
    .sts               (sts)
  );

endmodule

### tb/sender_sequence_dedup_table_core_tb.sv
// Self-checking testbench for the per-sender sequence id duplicate filter core.
module sender_sequence_dedup_table_core_tb
  import ssdt_pkg::*;
;

  localparam int NUM_SENDERS = 32;
  localparam int POOL_SIZE = 40;
  localparam int TARGET_PACKETS = 1850;

  class dup_filter_scoreboard;
    logic [MAC_W-1:0] slot_mac [NUM_SENDERS];
    logic [SEQ_W-1:0] slot_seq [NUM_SENDERS];
    int unsigned live_count = 0;
    int unsigned oldest = 0;
    logic dup_verdicts [$];
    int errors = 0;

    function void note_packet(logic [MAC_W-1:0] mac, logic present, logic [SEQ_W-1:0] seq);
      int unsigned k;
      int unsigned s;
      logic dup;
      logic found;
      dup = 1'b0;
      found = 1'b0;
      if (seq != '0 && present) begin
        for (k = 0; k < live_count && !found; k++) begin
          s = (oldest + k) % NUM_SENDERS;
          if (slot_mac[s] == mac) begin
            found = 1'b1;
            if (slot_seq[s] == seq) dup = 1'b1;
            else slot_seq[s] = seq;
          end
        end
        if (!found) begin
          if (live_count < NUM_SENDERS) begin
            s = (oldest + live_count) % NUM_SENDERS;
            live_count++;
          end else begin
            s = oldest;
            oldest = (oldest + 1) % NUM_SENDERS;
          end
          slot_mac[s] = mac;
          slot_seq[s] = seq;
        end
      end
      dup_verdicts.insert(dup_verdicts.size(), dup);
    endfunction

    function void check_verdict(logic actual);
      logic predicted;
      if (dup_verdicts.size() == 0) begin
        $error("is_duplicate: expected no transaction, actual %0b", actual);
        errors++;
      end else begin
        predicted = dup_verdicts.pop_front();
        if (actual !== predicted) begin
          $error("is_duplicate: expected %0b, actual %0b", predicted, actual);
          errors++;
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [MAC_W-1:0] in_sender_mac;
  logic in_sender_present;
  logic [SEQ_W-1:0] in_seq_id;
  logic out_valid;
  logic out_stall;
  logic out_is_duplicate;

  dup_filter_scoreboard sb = new;
  logic [MAC_W-1:0] mac_pool [POOL_SIZE];
  int unsigned burst_left = 0;
  int unsigned counted = 0;

  sender_sequence_dedup_table_core #(
    .MAX_SENDERS(NUM_SENDERS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_sender_mac(in_sender_mac),
    .in_sender_present(in_sender_present),
    .in_seq_id(in_seq_id),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_is_duplicate(out_is_duplicate)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #8000000;
    $display("FAIL sender_sequence_dedup_table_core");
    $finish;
  end

  task automatic send_packet(input logic [MAC_W-1:0] mac, input logic present,
                             input logic [SEQ_W-1:0] seq);
    int unsigned gap;
    in_valid <= 1'b1;
    in_sender_mac <= mac;
    in_sender_present <= present;
    in_seq_id <= seq;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_packet(mac, present, seq);
    counted++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(0, 8);
    end
  endtask

  task automatic refill_pool();
    int unsigned i;
    mac_pool[0] = {16'($urandom()), $urandom()};
    for (i = 1; i < POOL_SIZE / 2; i++) mac_pool[i] = {16'($urandom()), $urandom()};
    for (i = POOL_SIZE / 2; i < POOL_SIZE; i++)
      mac_pool[i] = mac_pool[0] ^ (48'd1 << (2 * i - POOL_SIZE + 1));
  endtask

  // receiver: check results, stall on a shifting pattern, hold off long twice
  initial begin
    int unsigned results;
    int unsigned cyc;
    int unsigned mode;
    int unsigned run_left;
    int unsigned hold_left;
    int unsigned long_holds;
    logic run_val;
    results = 0;
    cyc = 0;
    mode = 0;
    run_left = 0;
    hold_left = 0;
    long_holds = 0;
    run_val = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
        sb.check_verdict(out_is_duplicate);
        results++;
      end
      cyc++;
      if (cyc % 97 == 0) mode = $urandom_range(0, 3);
      if (hold_left == 0 && long_holds < 2 && results >= 200 + 800 * long_holds) begin
        hold_left = 300;
        long_holds++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 3) != 0);
          default: begin
            if (run_left == 0) begin
              run_left = $urandom_range(1, 12);
              run_val = ~run_val;
            end
            run_left--;
            out_stall <= run_val;
          end
        endcase
      end
    end
  end

  initial begin
    logic [MAC_W-1:0] mac_a;
    logic [SEQ_W-1:0] seq;
    logic present;
    int unsigned k;
    int unsigned j;
    int unsigned len;
    int unsigned pick;
    int unsigned next_refill;
    mac_a = 48'h0123_4567_89AB;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_sender_mac <= '0;
    in_sender_present <= 1'b0;
    in_seq_id <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_packet(48'hFFFF_FFFF_FFFF, 1'b0, 8'd5);
    send_packet(mac_a, 1'b1, 8'd0);
    send_packet(mac_a, 1'b1, 8'd1);
    send_packet(mac_a, 1'b1, 8'd1);
    send_packet(mac_a, 1'b1, 8'd0);
    send_packet(mac_a, 1'b1, 8'd1);
    send_packet(mac_a, 1'b0, 8'd1);
    send_packet(mac_a, 1'b1, 8'd2);
    send_packet(mac_a, 1'b1, 8'd2);
    send_packet(mac_a ^ 48'h8000_0000_0000, 1'b1, 8'd2);
    send_packet(48'hFFFF_FFFF_FFFF, 1'b1, 8'd255);
    send_packet(48'hFFFF_FFFF_FFFF, 1'b1, 8'd255);
    send_packet(48'h0, 1'b1, 8'd255);
    send_packet(48'h0, 1'b1, 8'd255);
    send_packet(48'h0, 1'b1, 8'd1);
    send_packet(mac_a, 1'b1, 8'd2);

    refill_pool();
    next_refill = counted + 400;
    while (counted < TARGET_PACKETS) begin
      if (counted >= next_refill) begin
        refill_pool();
        next_refill = counted + 400;
      end
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        len = $urandom_range(5, 40);
        repeat (len) begin
          k = $urandom_range(0, POOL_SIZE - 1);
          present = ($urandom_range(0, 29) != 0);
          seq = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(1, 3)) : 8'($urandom());
          send_packet(mac_pool[k], present, seq);
        end
      end else if (pick == 7) begin
        k = $urandom_range(0, POOL_SIZE - 1);
        seq = 8'($urandom_range(1, 255));
        for (j = 0; j <= NUM_SENDERS; j++) send_packet(mac_pool[(k + j) % POOL_SIZE], 1'b1, seq);
        send_packet(mac_pool[k], 1'b1, seq);
      end else begin
        len = $urandom_range(1, 8);
        repeat (len) begin
          present = 1'($urandom_range(0, 1));
          seq = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom());
          send_packet({16'($urandom()), $urandom()}, present, seq);
        end
      end
    end
    in_valid <= 1'b0;

    while (sb.dup_verdicts.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.errors == 0 && sb.dup_verdicts.size() == 0) begin
      $display("PASS sender_sequence_dedup_table_core");
    end else begin
      $display("FAIL sender_sequence_dedup_table_core");
    end
    $finish;
  end

endmodule
